// ----- rtl/trle_pkg.sv -----
// Package with the shared configuration type and register map of the TGA RLE pixel decoder.
`timescale 1ns / 1ps

package trle_pkg;

	// Register indexes on the configuration port (byte address is four times the index).
	localparam logic [1:0] REG_CHANNELS    = 2'd0;
	localparam logic [1:0] REG_COMPRESSED  = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

	localparam int unsigned ADDR_W = 4;

	// Header byte fields.
	localparam logic [7:0] RUN_BIT  = 8'b1000_0000;
	localparam logic [7:0] LEN_MASK = 8'b0111_1111;

	typedef struct packed {
		logic [2:0]  channels;
		logic        compressed;
		logic [31:0] pixel_count;
	} cfg_t;

endpackage

// ----- rtl/tga_rle_pixel_decoder.sv -----
// Top level of the TGA run-length pixel decoder with its configuration registers.
`timescale 1ns / 1ps

// The decoder takes the body of a TGA image one byte per beat on the input channel
// (in_valid, in_stall, data_byte) and delivers one beat per decoded pixel or run on
// the output channel (out_valid, out_stall, pixel_value, repeat_count, image_done,
// overrun). Header bytes and bytes that do not finish a pixel give no output beat.
// Throughput is one byte per cycle while in_stall is low: the front part updates
// all packet and pixel state in the cycle a byte is accepted, so the next byte
// follows directly. A pixel beat is written into a two-entry queue at the edge
// that accepts the byte completing it, and moves into the output register once
// that register is empty or its beat leaves. The front keeps taking bytes while
// a finished pixel waits for the receiver.
// When the receiver stalls, the output register holds its beat and the queue fills;
// in_stall rises only once the queue is full.
// Reset clears all decode state and the queue; the next byte then begins a new image
// whose pixel total is loaded from pixel_count. Registers return to three channels,
// compressed mode and a total of one pixel. Registers sit on an APB-style port:
// channels at 0x0, compressed at 0x4 and pixel_count at 0x8. They are to be written
// only while the decoder is idle; the block itself does not enforce this.

module tga_rle_pixel_decoder #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trle_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [8*MAX_CHANNELS-1:0]     pixel_value,
	output logic [7:0]                    repeat_count,
	output logic                          image_done,
	output logic                          overrun
);

	localparam int BEAT_W = 8 * MAX_CHANNELS + 10;

	trle_pkg::cfg_t cfg_q;

	logic              accept;
	logic              push;
	logic [BEAT_W-1:0] push_data;
	logic              q_full;
	logic              q_not_empty;
	logic [BEAT_W-1:0] q_head;
	logic              pop;
	logic [BEAT_W-1:0] out_data;
	logic              wr_en;

	// Configuration registers.
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels    <= 3'd3;
			cfg_q.compressed  <= 1'b1;
			cfg_q.pixel_count <= 32'd1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				trle_pkg::REG_CHANNELS:    cfg_q.channels    <= pwdata[2:0];
				trle_pkg::REG_COMPRESSED:  cfg_q.compressed  <= pwdata[0];
				trle_pkg::REG_PIXEL_COUNT: cfg_q.pixel_count <= pwdata;
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			trle_pkg::REG_CHANNELS:    prdata = {29'd0, cfg_q.channels};
			trle_pkg::REG_COMPRESSED:  prdata = {31'd0, cfg_q.compressed};
			trle_pkg::REG_PIXEL_COUNT: prdata = cfg_q.pixel_count;
			default:                   prdata = 32'd0;
		endcase
	end

	// The input is held off only while the queue has no room for a pixel beat.
	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	trle_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.push_data (push_data)
	);

	trle_queue #(
		.WIDTH(BEAT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	trle_back #(
		.WIDTH(BEAT_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

	assign pixel_value  = out_data[BEAT_W-1 -: 8*MAX_CHANNELS];
	assign repeat_count = out_data[9:2];
	assign image_done   = out_data[1];
	assign overrun      = out_data[0];

endmodule

// ----- rtl/trle_front.sv -----
// Front part: accepts stream bytes, tracks packets and pixels, and produces pixel beats.
`timescale 1ns / 1ps

module trle_front #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trle_pkg::cfg_t              cfg,
	input  logic                        accept,
	input  logic [7:0]                  data_byte,
	output logic                        push,
	output logic [8*MAX_CHANNELS+9:0]   push_data
);

	localparam int PIX_W = 8 * MAX_CHANNELS;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_RUN    = 2'd1;
	localparam logic [1:0] PH_RAW    = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic [7:0]       ppl_q, ppl_d;
	logic             ovr_q, ovr_d;
	logic [1:0]       idx_q, idx_d;
	logic [PIX_W-1:0] asm_q, asm_d, asm_new;
	logic [31:0]      ipl_q, ipl_d;

	logic [31:0] ipl;
	logic [2:0]  eff;
	logic        complete;
	logic [1:0]  idx_next;
	logic        emit;
	logic [7:0]  cnt;
	logic [7:0]  cnt_e;
	logic        emit_ovr;
	logic [7:0]  hdr_cnt;
	logic [7:0]  ppl_dec;
	logic [31:0] ipl_after;

	always_comb begin
		// A new image begins when the previous one is finished.
		if (ipl_q == 32'd0) begin
			ipl = (cfg.pixel_count == 32'd0) ? 32'd1 : cfg.pixel_count;
		end else begin
			ipl = ipl_q;
		end

		if (cfg.channels == 3'd0) begin
			eff = 3'd1;
		end else if (cfg.channels > 3'(MAX_CHANNELS)) begin
			eff = 3'(MAX_CHANNELS);
		end else begin
			eff = cfg.channels;
		end

		asm_new = asm_q;
		for (int k = 0; k < MAX_CHANNELS; k++) begin
			if (idx_q == 2'(k)) begin
				asm_new[8*k +: 8] = asm_q[8*k +: 8] | data_byte;
			end
		end

		complete = ({1'b0, idx_q} + 3'd1) >= eff;
		idx_next = complete ? 2'd0 : idx_q + 2'd1;

		phase_d  = phase_q;
		ppl_d    = ppl_q;
		ovr_d    = ovr_q;
		idx_d    = idx_next;
		asm_d    = asm_new;
		emit     = 1'b0;
		cnt      = 8'd1;
		emit_ovr = 1'b0;
		hdr_cnt  = {1'b0, data_byte[6:0]} + 8'd1;
		ppl_dec  = (ppl_q != 8'd0) ? ppl_q - 8'd1 : 8'd0;

		if (!cfg.compressed) begin
			if (complete) begin
				phase_d = PH_HEADER;
				ppl_d   = 8'd0;
				ovr_d   = 1'b0;
				emit    = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_RUN: begin
					if (complete) begin
						cnt      = ppl_q;
						ppl_d    = 8'd0;
						phase_d  = PH_HEADER;
						emit     = 1'b1;
						emit_ovr = ovr_q;
					end
				end
				PH_RAW: begin
					if (complete) begin
						ppl_d    = ppl_dec;
						if (ppl_dec == 8'd0) begin
							phase_d = PH_HEADER;
						end
						emit     = 1'b1;
						emit_ovr = ovr_q;
					end
				end
				default: begin
					// Packet header; the unused phase code lands here too.
					if ({24'd0, hdr_cnt} > ipl) begin
						ppl_d = ipl[7:0];
						ovr_d = 1'b1;
					end else begin
						ppl_d = hdr_cnt;
						ovr_d = 1'b0;
					end
					idx_d   = 2'd0;
					asm_d   = '0;
					phase_d = ((data_byte & trle_pkg::RUN_BIT) != 8'd0) ? PH_RUN : PH_RAW;
				end
			endcase
		end

		// Clamp the count to what remains of the image.
		cnt_e = (cnt == 8'd0) ? 8'd1 : cnt;
		if ({24'd0, cnt_e} > ipl) begin
			cnt_e = ipl[7:0];
		end
		ipl_after = ipl - {24'd0, cnt_e};

		ipl_d = ipl;
		if (emit) begin
			ipl_d = ipl_after;
			asm_d = '0;
		end
	end

	assign push      = accept & emit;
	assign push_data = {asm_new, cnt_e, (ipl_after == 32'd0), emit_ovr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ppl_q   <= 8'd0;
			ovr_q   <= 1'b0;
			idx_q   <= 2'd0;
			asm_q   <= '0;
			ipl_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			ppl_q   <= ppl_d;
			ovr_q   <= ovr_d;
			idx_q   <= idx_d;
			asm_q   <= asm_d;
			ipl_q   <= ipl_d;
		end
	end

endmodule

// ----- rtl/trle_queue.sv -----
// Two-entry queue that decouples the front part from the output stage.
`timescale 1ns / 1ps

module trle_queue #(
	parameter int WIDTH = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/trle_back.sv -----
// Back part: output register that presents pixel beats to the receiver.
`timescale 1ns / 1ps

module trle_back #(
	parameter int WIDTH = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  logic [WIDTH-1:0] q_head,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [WIDTH-1:0] out_data
);

	logic             valid_q;
	logic [WIDTH-1:0] data_q;

	// Refill whenever the register is empty or its beat leaves this cycle.
	assign pop       = q_not_empty & (~valid_q | ~out_stall);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ----- test/tga_rle_pixel_checker.sv -----
// Checker that predicts the decoder's pixel beats from the channels it watches and compares them.
`timescale 1ns / 1ps

module tga_rle_pixel_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [trle_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [31:0]                 pixel_value,
	input  logic [7:0]                  repeat_count,
	input  logic                        image_done,
	input  logic                        overrun,
	output int unsigned                 failures,
	output int unsigned                 pending,
	output logic                        at_image_start
);

	typedef enum logic [1:0] {
		AWAIT_HEADER,
		RUN_BYTES,
		RAW_BYTES
	} packet_phase_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_done;
		logic        overrun;
	} pixel_beat_t;

	pixel_beat_t expected_pixels[$];
	int unsigned mismatch_total;

	logic [2:0]    cfg_channels;
	logic          cfg_compressed;
	logic [31:0]   cfg_pixel_count;

	packet_phase_t packet_phase;
	logic          packet_clamped;
	logic [7:0]    packet_left;
	logic [1:0]    byte_idx;
	logic [31:0]   pixel_acc;
	logic [31:0]   image_left;

	// Adds a byte to the pixel being built and tells whether the pixel is now complete.
	function automatic bit add_pixel_byte(input logic [7:0] b);
		int unsigned nch;
		nch = (cfg_channels == 3'd0) ? 1 : (cfg_channels > 3'd4) ? 4 : int'(cfg_channels);
		pixel_acc = pixel_acc | (32'(b) << (8 * byte_idx));
		if (int'(byte_idx) + 1 >= nch) begin
			byte_idx = 2'd0;
			return 1'b1;
		end
		byte_idx = byte_idx + 2'd1;
		return 1'b0;
	endfunction

	function automatic void push_pixel(input int unsigned count, input logic clamped);
		pixel_beat_t beat;
		int unsigned n;
		n = (count == 0) ? 1 : count;
		if (n > image_left)
			n = image_left;
		image_left = image_left - n;
		beat.pixel_value  = pixel_acc;
		beat.repeat_count = 8'(n);
		beat.image_done   = (image_left == 32'd0);
		beat.overrun      = clamped;
		expected_pixels.insert(expected_pixels.size(), beat);
		pixel_acc = 32'd0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		int unsigned run_len;
		// A byte that arrives with no pixels left opens a new image.
		if (image_left == 32'd0)
			image_left = (cfg_pixel_count == 32'd0) ? 32'd1 : cfg_pixel_count;
		if (!cfg_compressed) begin
			// Raw pass-through: a finished pixel also closes whatever packet was open.
			if (add_pixel_byte(b)) begin
				packet_phase   = AWAIT_HEADER;
				packet_left    = 8'd0;
				packet_clamped = 1'b0;
				push_pixel(1, 1'b0);
			end
		end else begin
			case (packet_phase)
				RUN_BYTES: begin
					if (add_pixel_byte(b)) begin
						push_pixel(packet_left, packet_clamped);
						packet_left  = 8'd0;
						packet_phase = AWAIT_HEADER;
					end
				end
				RAW_BYTES: begin
					if (add_pixel_byte(b)) begin
						if (packet_left > 8'd0)
							packet_left = packet_left - 8'd1;
						if (packet_left == 8'd0)
							packet_phase = AWAIT_HEADER;
						push_pixel(1, packet_clamped);
					end
				end
				default: begin
					run_len = int'(b & trle_pkg::LEN_MASK) + 1;
					packet_clamped = 1'b0;
					if (run_len > image_left) begin
						run_len = image_left;
						packet_clamped = 1'b1;
					end
					packet_left  = 8'(run_len);
					byte_idx     = 2'd0;
					pixel_acc    = 32'd0;
					packet_phase = ((b & trle_pkg::RUN_BIT) != 8'd0) ? RUN_BYTES : RAW_BYTES;
				end
			endcase
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_beat_t want;
		if (!arst_n) begin
			cfg_channels    = 3'd3;
			cfg_compressed  = 1'b1;
			cfg_pixel_count = 32'd1;
			packet_phase    = AWAIT_HEADER;
			packet_clamped  = 1'b0;
			packet_left     = 8'd0;
			byte_idx        = 2'd0;
			pixel_acc       = 32'd0;
			image_left      = 32'd0;
			mismatch_total  = 0;
			expected_pixels.delete();
			failures       <= 0;
			pending        <= 0;
			at_image_start <= 1'b1;
		end else begin
			// The output side is handled first, so a beat can never match an
			// expectation made at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel beat: pixel_value %h repeat_count %0d",
						pixel_value, repeat_count);
					mismatch_total++;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_value !== want.pixel_value) begin
						$error("pixel_value: expected %h, got %h", want.pixel_value, pixel_value);
						mismatch_total++;
					end
					if (repeat_count !== want.repeat_count) begin
						$error("repeat_count: expected %0d, got %0d",
							want.repeat_count, repeat_count);
						mismatch_total++;
					end
					if (image_done !== want.image_done) begin
						$error("image_done: expected %b, got %b", want.image_done, image_done);
						mismatch_total++;
					end
					if (overrun !== want.overrun) begin
						$error("overrun: expected %b, got %b", want.overrun, overrun);
						mismatch_total++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[trle_pkg::ADDR_W-1:2])
					trle_pkg::REG_CHANNELS:    cfg_channels = pwdata[2:0];
					trle_pkg::REG_COMPRESSED:  cfg_compressed = pwdata[0];
					trle_pkg::REG_PIXEL_COUNT: cfg_pixel_count = pwdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte);
			failures       <= mismatch_total;
			pending        <= expected_pixels.size();
			at_image_start <= (image_left == 32'd0) && (byte_idx == 2'd0)
				&& (packet_phase == AWAIT_HEADER);
		end
	end

endmodule

// ----- test/tga_rle_pixel_decoder_tb.sv -----
// Top of the TGA run-length pixel decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;

	typedef logic [7:0] byte_q_t[$];

	localparam int unsigned ITEM_TARGET = 1050;
	// Cycles allowed for a byte to work its way through the decoder and queue.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES = 300;
	// Far above the slowest correct run, including every idle and stall phase.
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [trle_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    data_byte = 8'd0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [31:0]                   pixel_value;
	logic [7:0]                    repeat_count;
	logic                          image_done;
	logic                          overrun;

	int unsigned         failures;
	int unsigned         pending;
	logic                at_image_start;

	// Knobs shared by the stimulus and the receiver: percentages of idle cycles on
	// each side, and a request count for long receiver hold-offs.
	int unsigned         idle_pct = 0;
	int unsigned         stall_pct = 0;
	int unsigned         hold_requests = 0;
	int unsigned         bytes_sent = 0;
	int unsigned         cycle_count = 0;

	tga_rle_pixel_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_done   (image_done),
		.overrun      (overrun)
	);

	tga_rle_pixel_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_value    (pixel_value),
		.repeat_count   (repeat_count),
		.image_done     (image_done),
		.overrun        (overrun),
		.failures       (failures),
		.pending        (pending),
		.at_image_start (at_image_start)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver side. A hold-off request keeps out_stall high for a long stretch, so
	// the output register and the queue behind it fill and the decoder must stall
	// its input. Otherwise the receiver stalls at random at the current rate.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// The watchdog ends a run that hangs, for example when a pixel beat never comes.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tga_rle_pixel_decoder_tb failed");
		$finish;
	end

	// A register write: setup cycle, then access cycle; the write lands at the edge
	// that closes the access cycle.
	task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_config(input logic [2:0] channels, input logic compressed,
		input logic [31:0] pixel_count);
		apb_write(trle_pkg::REG_CHANNELS, 32'(channels));
		apb_write(trle_pkg::REG_COMPRESSED, 32'(compressed));
		apb_write(trle_pkg::REG_PIXEL_COUNT, pixel_count);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Adds one byte at the tail of a byte stream.
	function automatic void append_byte(ref byte_q_t bytes, input logic [7:0] b);
		bytes.insert(bytes.size(), b);
	endfunction

	// Offers one byte, with random idle cycles ahead of it, and returns at the edge
	// where the beat is taken. in_valid stays high so back-to-back bytes need no gap.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_stream(input byte_q_t bytes);
		foreach (bytes[i])
			send_byte(bytes[i]);
		in_valid <= 1'b0;
	endtask

	// Waits until the checker has seen the last byte, then until every
	// predicted pixel beat has arrived, then lets the pipeline drain, since header
	// bytes and partial pixels leave no expectation behind.
	task automatic settle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// After a broken stream the decoder can be anywhere inside an image. Feeding
	// one-byte raw pixels walks it to the end of that image; the mode and channel
	// change lands in the middle of a packet or pixel, which is worth covering too.
	task automatic realign_to_image_start();
		if (!at_image_start) begin
			apb_write(trle_pkg::REG_COMPRESSED, 32'd0);
			apb_write(trle_pkg::REG_CHANNELS, 32'd1);
			while (!at_image_start) begin
				send_byte(pick_byte());
				in_valid <= 1'b0;
				@(posedge clk);
			end
			settle();
		end
	endtask

	// Appends one complete image: raw pixels, or a sequence of run and raw packets.
	// Packet lengths are random, so the last packet often overshoots the image end.
	function automatic void build_image(input int unsigned nch, input bit compressed,
		input int unsigned total, ref byte_q_t bytes);
		int unsigned left;
		int unsigned run_len;
		bit          is_run;
		left = (total == 0) ? 1 : total;
		if (!compressed) begin
			repeat (left * nch) append_byte(bytes, pick_byte());
		end else begin
			while (left > 0) begin
				run_len = ($urandom_range(3) == 0) ? $urandom_range(128, 1) : $urandom_range(8, 1);
				is_run = $urandom_range(1);
				append_byte(bytes, {is_run, 7'(run_len - 1)});
				if (run_len > left)
					run_len = left;
				repeat (is_run ? nch : run_len * nch) append_byte(bytes, pick_byte());
				left -= run_len;
			end
		end
	endfunction

	initial begin : stimulus
		byte_q_t     bytes;
		int unsigned phase_no;
		int unsigned nch;
		logic [2:0]  channels;
		logic        compressed;
		logic [31:0] pixel_count;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A run of two pixels with the byte extremes, then a raw
		// packet that finishes a three-pixel image.
		write_config(3'd3, 1'b1, 32'd3);
		send_stream('{8'h81, 8'h00, 8'hFF, 8'hA5, 8'h00, 8'hFF, 8'hFF, 8'hFF});
		settle();
		// A zero pixel count means one pixel; the longest run is clamped to it.
		write_config(3'd4, 1'b1, 32'd0);
		send_stream('{8'hFF, 8'h12, 8'h34, 8'h56, 8'h78});
		settle();
		// Zero channels means one byte per pixel, in raw pass-through mode.
		write_config(3'd0, 1'b0, 32'd3);
		send_stream('{8'h7F, 8'h80, 8'h01});
		settle();
		// Channels shrink while a pixel is half built, so it completes on the next
		// byte. Then pass-through mode cuts the raw packet short, with an
		// out-of-range channel count that acts as four.
		write_config(3'd4, 1'b1, 32'd2);
		send_stream('{8'h01, 8'hAA, 8'hBB});
		settle();
		apb_write(trle_pkg::REG_CHANNELS, 32'd2);
		send_stream('{8'hCC});
		settle();
		apb_write(trle_pkg::REG_COMPRESSED, 32'd0);
		apb_write(trle_pkg::REG_CHANNELS, 32'd7);
		send_stream('{8'h11, 8'h22, 8'h33, 8'h44});
		settle();

		// Random phases: well-formed images with random content under changing
		// settings and idle patterns, with a broken stream now and then.
		phase_no = 0;
		while (bytes_sent < ITEM_TARGET) begin
			realign_to_image_start();
			case (phase_no % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 68; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 68; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			channels = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 1));
			if ($urandom_range(15) == 0)
				channels = 3'd0;
			compressed = ($urandom_range(3) != 0);
			if (!compressed)
				pixel_count = $urandom_range(30, 1);
			else if ($urandom_range(5) == 0)
				pixel_count = $urandom_range(300, 129);
			else
				pixel_count = $urandom_range(40, 1);
			if ($urandom_range(9) == 0)
				pixel_count = 32'd0;
			write_config(channels, compressed, pixel_count);

			nch = (channels == 3'd0) ? 1 : (channels > 3'd4) ? 4 : int'(channels);
			bytes.delete();
			while (bytes.size() < 60)
				build_image(nch, compressed, pixel_count, bytes);
			if ($urandom_range(4) == 0) begin
				if ($urandom_range(1))
					repeat ($urandom_range(bytes.size() - 1)) void'(bytes.pop_back());
				else
					repeat (3) bytes.insert($urandom_range(bytes.size()), pick_byte());
			end
			// The receiver-stall phases also hold off long enough to back up the input.
			if (phase_no % 4 == 2)
				hold_requests++;
			send_stream(bytes);
			settle();
			phase_no++;
		end

		// An image of 65535 x 65535 pixels: only the opening packets are sent.
		realign_to_image_start();
		idle_pct = 0;
		stall_pct = 0;
		write_config(3'd4, 1'b1, 32'd4294836225);
		bytes.delete();
		repeat (6) begin
			if ($urandom_range(1)) begin
				append_byte(bytes, 8'hFF);
				repeat (4) append_byte(bytes, pick_byte());
			end else begin
				append_byte(bytes, 8'h03);
				repeat (16) append_byte(bytes, pick_byte());
			end
		end
		send_stream(bytes);
		settle();

		if (failures == 0 && pending == 0)
			$display("tga_rle_pixel_decoder_tb passed");
		else
			$display("tga_rle_pixel_decoder_tb failed");
		$finish;
	end

endmodule
